@@ sv/otp_monotonic_version_counter_defines.svh @@
// Assertion macros for the version counter.
`ifndef OTP_MONOTONIC_VERSION_COUNTER_DEFINES_SVH
`define OTP_MONOTONIC_VERSION_COUNTER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/otp_mvc_pkg.sv @@
package otp_mvc_pkg;

    localparam int LOW_CAPACITY   = 32;
    localparam int HIGH_CAPACITY  = 32;
    localparam bit HIGH_BANK_USED = 1'b1;

    localparam int FUSE_W  = 32;
    localparam int COUNT_W = 7;
    localparam int BANK_CNT_W = 6;

    localparam logic [COUNT_W-1:0] CAPACITY =
        COUNT_W'(LOW_CAPACITY + (HIGH_BANK_USED ? HIGH_CAPACITY : 0));

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECURE_BOOT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENFORCE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MASK   = 3'd4;

    typedef enum logic {
        OP_READ    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_PROG_DISABLED = 2'd1,
        STATUS_OVER_CAPACITY = 2'd2
    } status_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] requested_version;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] version_count;
        status_t            status;
        logic               fuses_written;
    } rsp_t;

    typedef struct packed {
        logic              programming_enabled;
        logic              secure_boot_on;
        logic              enforcement_on;
        logic [FUSE_W-1:0] low_bank_mask;
        logic [FUSE_W-1:0] high_bank_mask;
    } cfg_t;

    function automatic logic [BANK_CNT_W-1:0] ones_in(logic [FUSE_W-1:0] x);
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s4;
        logic [7:0]  sum;
        s1  = x - ((x >> 1) & 32'h5555_5555);
        s2  = (s1 & 32'h3333_3333) + ((s1 >> 2) & 32'h3333_3333);
        s4  = (s2 + (s2 >> 4)) & 32'h0f0f_0f0f;
        sum = s4[7:0] + s4[15:8] + s4[23:16] + s4[31:24];
        return BANK_CNT_W'(sum);
    endfunction

    // n low bits set; n of 32 or more gives all ones
    function automatic logic [FUSE_W-1:0] thermometer(logic [BANK_CNT_W-1:0] n);
        logic [FUSE_W-1:0] t;
        for (int i = 0; i < FUSE_W; i++) begin
            t[i] = (BANK_CNT_W'(i) < n);
        end
        return t;
    endfunction

endpackage

@@ sv/otp_mvc_cfg.sv @@
module otp_mvc_cfg
    import otp_mvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 we,
    input  logic [CFG_IDX_W-1:0] index,
    input  logic [31:0]          data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            case (index)
                CFG_PROG_EN:     cfg_next.programming_enabled = data[0];
                CFG_SECURE_BOOT: cfg_next.secure_boot_on      = data[0];
                CFG_ENFORCE:     cfg_next.enforcement_on      = data[0];
                CFG_LOW_MASK:    cfg_next.low_bank_mask       = data;
                CFG_HIGH_MASK:   cfg_next.high_bank_mask      = data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.programming_enabled <= 1'b0;
            cfg_reg.secure_boot_on      <= 1'b0;
            cfg_reg.enforcement_on      <= 1'b0;
            cfg_reg.low_bank_mask       <= '1;
            cfg_reg.high_bank_mask      <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/otp_mvc_eval.sv @@
module otp_mvc_eval
    import otp_mvc_pkg::*;
(
    input  req_t              req,
    input  cfg_t              cfg,
    input  logic [FUSE_W-1:0] low_fuses,
    input  logic [FUSE_W-1:0] high_fuses,
    output rsp_t              rsp,
    output logic              fuse_we,
    output logic [FUSE_W-1:0] new_low,
    output logic [FUSE_W-1:0] new_high
);

    logic                  active;
    logic [BANK_CNT_W-1:0] cnt_low;
    logic [BANK_CNT_W-1:0] cnt_high;
    logic [COUNT_W-1:0]    cur;
    logic                  above_cur;
    logic                  above_cap;
    logic [BANK_CNT_W-1:0] low_n;
    logic [BANK_CNT_W-1:0] high_n;
    logic [31:0]           high_diff;

    assign active   = cfg.secure_boot_on & cfg.enforcement_on;
    assign cnt_low  = ones_in(low_fuses & cfg.low_bank_mask);
    assign cnt_high = HIGH_BANK_USED ? ones_in(high_fuses & cfg.high_bank_mask)
                                     : '0;
    assign cur = active ? (COUNT_W'(cnt_low) + COUNT_W'(cnt_high)) : '0;

    assign above_cur = req.requested_version > {{(32-COUNT_W){1'b0}}, cur};
    assign above_cap = req.requested_version > {{(32-COUNT_W){1'b0}}, CAPACITY};

    // split the target across banks; only used when within capacity
    assign low_n = (req.requested_version < 32'(LOW_CAPACITY))
                 ? BANK_CNT_W'(req.requested_version)
                 : BANK_CNT_W'(LOW_CAPACITY);
    assign high_diff = req.requested_version - 32'(LOW_CAPACITY);
    assign high_n = (req.requested_version > 32'(LOW_CAPACITY))
                  ? BANK_CNT_W'(high_diff) : '0;

    assign new_low  = low_fuses  | thermometer(low_n);
    assign new_high = high_fuses | thermometer(high_n);

    always_comb
    begin
        fuse_we           = 1'b0;
        rsp.version_count = cur;
        rsp.status        = STATUS_OK;
        rsp.fuses_written = 1'b0;
        if (req.operation == OP_ADVANCE)
        begin
            if (!cfg.programming_enabled)
            begin
                rsp.status = STATUS_PROG_DISABLED;
            end
            else if (active && above_cur)
            begin
                if (above_cap)
                begin
                    rsp.status = STATUS_OVER_CAPACITY;
                end
                else
                begin
                    fuse_we           = 1'b1;
                    rsp.fuses_written = (new_low != low_fuses) || (new_high != high_fuses);
                end
            end
        end
    end

endmodule

@@ sv/otp_monotonic_version_counter.sv @@
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data (req_t)
// out     | output    | out_valid/out_ready  | out_data (rsp_t)
// cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A request is held in the input register, evaluated against the fuse banks
// and lands in the output register; one request per cycle unless the output
// stalls. Fuse banks update on the same edge, so the next request sees them.
// Reset clears fuses and config flags, sets masks to ones; cfg_ready is
// always high. A stalled output holds one result and one more request waits.
`include "otp_monotonic_version_counter_defines.svh"

module otp_monotonic_version_counter
    import otp_mvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsp_t                 out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t              cfg;
    req_t              req_reg;
    logic              req_valid_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;
    logic [FUSE_W-1:0] low_fuses_reg;
    logic [FUSE_W-1:0] high_fuses_reg;

    rsp_t              rsp_next;
    logic              fuse_we;
    logic [FUSE_W-1:0] low_fuses_next;
    logic [FUSE_W-1:0] high_fuses_next;
    logic              advance;

    assign cfg_ready = 1'b1;

    otp_mvc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_valid & cfg_ready),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    otp_mvc_eval u_eval (
        .req        (req_reg),
        .cfg        (cfg),
        .low_fuses  (low_fuses_reg),
        .high_fuses (high_fuses_reg),
        .rsp        (rsp_next),
        .fuse_we    (fuse_we),
        .new_low    (low_fuses_next),
        .new_high   (high_fuses_next)
    );

    // request moves into the output register
    assign advance  = req_valid_reg && (!rsp_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            low_fuses_reg  <= '0;
            high_fuses_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (advance && fuse_we)
            begin
                low_fuses_reg  <= low_fuses_next;
                high_fuses_reg <= high_fuses_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_valid = rsp_valid_reg;
    assign out_data  = rsp_reg;

    // fuses are one-time: no bit ever clears
    `ASSERT_NEXT(a_fuse_monotonic, clk, rst_n, 1'b1,
        ((low_fuses_reg & $past(low_fuses_reg)) == $past(low_fuses_reg)) &&
        ((high_fuses_reg & $past(high_fuses_reg)) == $past(high_fuses_reg)))
    // banks only change on a committed write
    `ASSERT_NEXT(a_fuse_hold, clk, rst_n, !(advance && fuse_we),
        $stable(low_fuses_reg) && $stable(high_fuses_reg))
    // a write is only reported with ok status
    `ASSERT_IMPLIES(a_written_ok, clk, rst_n, out_valid && out_data.fuses_written,
        out_data.status == STATUS_OK)
    // reported version never above the combined capacity
    `ASSERT_IMPLIES(a_count_range, clk, rst_n, out_valid,
        out_data.version_count <= CAPACITY)

endmodule
